// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer slot RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSLOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer slot assertion failed");

// Next-cycle implication, disabled during reset.
`define TSLOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer slot assertion failed");

`endif

// ===== hdl/tslot_pkg.sv =====
// Package with the types and codes of the timer slot block.
`timescale 1ns / 1ps
`default_nettype none

package tslot_pkg;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_SERVICE      = 2'd0,
        OP_SET_TIMEOUT  = 2'd1,
        OP_SET_INTERVAL = 2'd2,
        OP_CANCEL       = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_TIMEOUT   = 3'd0,
        KIND_INTERVAL  = 3'd1,
        KIND_ARMED     = 3'd2,
        KIND_REJECTED  = 3'd3,
        KIND_CANCELLED = 3'd4
    } t_kind;

    // Repeat count that never frees an interval.
    localparam logic signed [16:0] REPEAT_FOREVER = -17'sd1;

    // One result without its last flag.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot_index;
        logic [7:0]  tag;
    } t_result;

    // Outputs of the shared add and compare unit.
    typedef struct packed {
        logic [31:0] sum;
        logic        lt;
    } t_alu_res;

endpackage

`default_nettype wire

// ===== hdl/tslot_if.sv =====
// Valid/ready channel interfaces for timer slot requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface tslot_in_if;
    logic               valid;
    logic               ready;
    tslot_pkg::t_op     operation;
    logic [31:0]        now;
    logic [30:0]        duration;
    logic signed [16:0] repeat_count;
    logic [7:0]         callback_tag;
    logic [3:0]         slot;

    modport source (
        output valid, operation, now, duration, repeat_count, callback_tag, slot,
        input  ready
    );
    modport sink (
        input  valid, operation, now, duration, repeat_count, callback_tag, slot,
        output ready
    );
endinterface

interface tslot_out_if;
    logic              valid;
    logic              ready;
    tslot_pkg::t_kind  kind;
    logic [3:0]        slot_index;
    logic [7:0]        tag;
    logic              last;

    modport source (
        output valid, kind, slot_index, tag, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot_index, tag, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/timeout_interval_timer_slots_top.sv =====
// Service check: after accept the walk visits each timeout slot, then each interval slot,
// one slot per cycle unless a fire finds the output register full; a flush ends the item.
// Set: accept, a walk up to the first free slot, then flush; a zero duration or an out-of-range
// cancel goes straight to flush, a cancel in range passes through the cancel state first.
// One item at a time; ready only while idle. Reset clears the armed bits and the sequencer;
// the slot memories are only used for armed slots and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module timeout_interval_timer_slots_top #(
    parameter int TIMEOUT_SLOTS  = 16,
    parameter int INTERVAL_SLOTS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tslot_in_if.sink     i_in,
    tslot_out_if.source  o_out
);

    localparam int TW = (TIMEOUT_SLOTS > 1) ? $clog2(TIMEOUT_SLOTS) : 1;
    localparam int IW = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
    localparam int XW = (TW > IW) ? TW : IW;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_TSCAN  = 7'b0000010,
        ST_ISCAN  = 7'b0000100,
        ST_FIND_T = 7'b0001000,
        ST_FIND_I = 7'b0010000,
        ST_CANCEL = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } t_state;

    // Sequencer and status registers
    t_state                 r_state, n_state;
    logic [XW-1:0]          r_idx, n_idx;
    logic                   r_pend_valid, n_pend_valid;
    tslot_pkg::t_result     r_pend, n_pend;
    logic [TIMEOUT_SLOTS-1:0]  r_to_armed, n_to_armed;
    logic [INTERVAL_SLOTS-1:0] r_iv_act, n_iv_act;

    // Captured request
    logic [31:0]            r_now;
    logic [30:0]            r_dur;
    logic signed [16:0]     r_rc;
    logic [7:0]             r_ctag;

    // Output register
    logic                   r_out_valid;
    tslot_pkg::t_result     r_out;
    logic                   r_out_last;

    // Slot memories
    logic [31:0]            r_to_dl     [TIMEOUT_SLOTS];
    logic [7:0]             r_to_tag    [TIMEOUT_SLOTS];
    logic [31:0]            r_iv_due    [INTERVAL_SLOTS];
    logic [30:0]            r_iv_period [INTERVAL_SLOTS];
    logic signed [16:0]     r_iv_limit  [INTERVAL_SLOTS];
    logic [15:0]            r_iv_fired  [INTERVAL_SLOTS];
    logic [7:0]             r_iv_tag    [INTERVAL_SLOTS];

    // Registered read data
    logic [31:0]            r_rd_dl;
    logic [7:0]             r_rd_totag;
    logic [31:0]            r_rd_due;
    logic [30:0]            r_rd_period;
    logic signed [16:0]     r_rd_limit;
    logic [15:0]            r_rd_fired;
    logic [7:0]             r_rd_ivtag;

    logic                   accept;
    logic                   out_free;
    logic                   push;
    logic                   push_last;
    logic                   to_we;
    logic                   iv_due_we;
    logic                   iv_fired_we;
    logic                   iv_cfg_we;
    logic [15:0]            fired_wr;
    logic [15:0]            fired_inc;
    logic signed [16:0]     fired_ext;
    logic                   iv_done;
    logic                   to_fire;
    logic                   iv_fire;
    logic                   idx_last_t;
    logic                   idx_last_i;
    logic [TW-1:0]          ti;
    logic [IW-1:0]          ii;
    logic [31:0]            alu_a;
    logic [31:0]            alu_b;
    tslot_pkg::t_alu_res    alu;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign ti       = r_idx[TW-1:0];
    assign ii       = r_idx[IW-1:0];

    assign idx_last_t = (r_idx == XW'(TIMEOUT_SLOTS - 1));
    assign idx_last_i = (r_idx == XW'(INTERVAL_SLOTS - 1));

    // Select operands of the shared unit
    always_comb begin
        alu_a = r_now;
        alu_b = {1'b0, r_dur};
        if (r_state == ST_TSCAN) begin
            alu_a = r_rd_dl;
        end else if (r_state == ST_ISCAN) begin
            alu_a = r_rd_due;
            alu_b = {1'b0, r_rd_period};
        end
    end

    tslot_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_cmp (r_now),
        .o_res (alu)
    );

    assign to_fire   = r_to_armed[ti] && alu.lt;
    assign iv_fire   = r_iv_act[ii] && alu.lt;
    assign fired_inc = r_rd_fired + 16'd1;
    assign fired_ext = $signed({1'b0, fired_inc});
    assign iv_done   = (r_rd_limit != tslot_pkg::REPEAT_FOREVER) && (fired_ext >= r_rd_limit);

    // Sequence the slot walk
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_to_armed   = r_to_armed;
        n_iv_act     = r_iv_act;
        push         = 1'b0;
        push_last    = 1'b0;
        to_we        = 1'b0;
        iv_due_we    = 1'b0;
        iv_fired_we  = 1'b0;
        iv_cfg_we    = 1'b0;
        fired_wr     = 16'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    unique case (i_in.operation)
                        tslot_pkg::OP_SERVICE: begin
                            n_state = ST_TSCAN;
                        end
                        tslot_pkg::OP_SET_TIMEOUT, tslot_pkg::OP_SET_INTERVAL: begin
                            if (i_in.duration == 31'd0) begin
                                n_pend       = '{tslot_pkg::KIND_REJECTED, 4'd0,
                                                 i_in.callback_tag};
                                n_pend_valid = 1'b1;
                                n_state      = ST_FLUSH;
                            end else if (i_in.operation == tslot_pkg::OP_SET_TIMEOUT) begin
                                n_state = ST_FIND_T;
                            end else begin
                                n_state = ST_FIND_I;
                            end
                        end
                        tslot_pkg::OP_CANCEL: begin
                            if (32'(i_in.slot) >= INTERVAL_SLOTS) begin
                                n_pend       = '{tslot_pkg::KIND_REJECTED, i_in.slot, 8'd0};
                                n_pend_valid = 1'b1;
                                n_state      = ST_FLUSH;
                            end else begin
                                n_idx   = XW'(i_in.slot);
                                n_state = ST_CANCEL;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TSCAN: begin
                if (!(to_fire && r_pend_valid && !out_free)) begin
                    if (to_fire) begin
                        push           = r_pend_valid;
                        n_pend         = '{tslot_pkg::KIND_TIMEOUT, 4'(r_idx), r_rd_totag};
                        n_pend_valid   = 1'b1;
                        n_to_armed[ti] = 1'b0;
                    end
                    if (idx_last_t) begin
                        n_idx   = '0;
                        n_state = ST_ISCAN;
                    end else begin
                        n_idx = r_idx + XW'(1);
                    end
                end
            end
            ST_ISCAN: begin
                if (!(iv_fire && r_pend_valid && !out_free)) begin
                    if (iv_fire) begin
                        push         = r_pend_valid;
                        n_pend       = '{tslot_pkg::KIND_INTERVAL, 4'(r_idx), r_rd_ivtag};
                        n_pend_valid = 1'b1;
                        iv_due_we    = 1'b1;
                        iv_fired_we  = 1'b1;
                        fired_wr     = iv_done ? 16'd0 : fired_inc;
                        if (iv_done) begin
                            n_iv_act[ii] = 1'b0;
                        end
                    end
                    if (idx_last_i) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + XW'(1);
                    end
                end
            end
            ST_FIND_T: begin
                if (!r_to_armed[ti]) begin
                    to_we          = 1'b1;
                    n_to_armed[ti] = 1'b1;
                    n_pend         = '{tslot_pkg::KIND_ARMED, 4'(r_idx), r_ctag};
                    n_pend_valid   = 1'b1;
                    n_state        = ST_FLUSH;
                end else if (idx_last_t) begin
                    n_pend       = '{tslot_pkg::KIND_REJECTED, 4'd0, r_ctag};
                    n_pend_valid = 1'b1;
                    n_state      = ST_FLUSH;
                end else begin
                    n_idx = r_idx + XW'(1);
                end
            end
            ST_FIND_I: begin
                if (!r_iv_act[ii]) begin
                    iv_due_we    = 1'b1;
                    iv_fired_we  = 1'b1;
                    iv_cfg_we    = 1'b1;
                    n_iv_act[ii] = 1'b1;
                    n_pend       = '{tslot_pkg::KIND_ARMED, 4'(r_idx), r_ctag};
                    n_pend_valid = 1'b1;
                    n_state      = ST_FLUSH;
                end else if (idx_last_i) begin
                    n_pend       = '{tslot_pkg::KIND_REJECTED, 4'd0, r_ctag};
                    n_pend_valid = 1'b1;
                    n_state      = ST_FLUSH;
                end else begin
                    n_idx = r_idx + XW'(1);
                end
            end
            ST_CANCEL: begin
                n_pend       = '{tslot_pkg::KIND_CANCELLED, 4'(r_idx),
                                 r_iv_act[ii] ? r_rd_ivtag : 8'd0};
                n_pend_valid = 1'b1;
                n_iv_act[ii] = 1'b0;
                n_state      = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_to_armed   <= '0;
            r_iv_act     <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_to_armed   <= n_to_armed;
            r_iv_act     <= n_iv_act;
        end
    end

    // Hold the pending result and the captured request
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (accept) begin
            r_now  <= i_in.now;
            r_dur  <= i_in.duration;
            r_rc   <= i_in.repeat_count;
            r_ctag <= i_in.callback_tag;
        end
    end

    // Timeout memories: write at the walk index, read at the next index
    always_ff @(posedge i_clk) begin
        if (to_we) begin
            r_to_dl[ti]  <= alu.sum;
            r_to_tag[ti] <= r_ctag;
        end
        r_rd_dl    <= r_to_dl[n_idx[TW-1:0]];
        r_rd_totag <= r_to_tag[n_idx[TW-1:0]];
    end

    // Interval memories: write at the walk index, read at the next index
    always_ff @(posedge i_clk) begin
        if (iv_due_we) begin
            r_iv_due[ii] <= alu.sum;
        end
        if (iv_fired_we) begin
            r_iv_fired[ii] <= fired_wr;
        end
        if (iv_cfg_we) begin
            r_iv_period[ii] <= r_dur;
            r_iv_limit[ii]  <= r_rc;
            r_iv_tag[ii]    <= r_ctag;
        end
        r_rd_due    <= r_iv_due[n_idx[IW-1:0]];
        r_rd_period <= r_iv_period[n_idx[IW-1:0]];
        r_rd_limit  <= r_iv_limit[n_idx[IW-1:0]];
        r_rd_fired  <= r_iv_fired[n_idx[IW-1:0]];
        r_rd_ivtag  <= r_iv_tag[n_idx[IW-1:0]];
    end

    // Drive the output register; a new transfer loads it when it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out      <= r_pend;
            r_out_last <= push_last;
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.slot_index = r_out.slot_index;
    assign o_out.tag        = r_out.tag;
    assign o_out.last       = r_out_last;

    // A finished item leaves nothing pending
    `TSLOT_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_valid)
    // An accepted item keeps the block busy in the next cycle
    `TSLOT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_in.ready)
    // A result that is not the final one implies the item is still in progress
    `TSLOT_ASSERT_IMP(a_not_last_busy, i_clk, i_rst_n, r_out_valid && !r_out_last,
                      r_state != ST_IDLE)
    // A new result is loaded only into a free output register
    `TSLOT_ASSERT_IMP(a_push_free, i_clk, i_rst_n, push, out_free)

endmodule

`default_nettype wire

// ===== hdl/tslot_alu.sv =====
// Shared 32-bit adder and unsigned less-than compare of the slot sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tslot_alu (
    input  wire logic [31:0]        i_a,
    input  wire logic [31:0]        i_b,
    input  wire logic [31:0]        i_cmp,
    output tslot_pkg::t_alu_res     o_res
);

    // Add for deadline updates, compare the deadline against now.
    assign o_res.sum = i_a + i_b;
    assign o_res.lt  = (i_a < i_cmp);

endmodule

`default_nettype wire

// ===== tb/timeout_interval_timer_slots_top_tb.sv =====
// Testbench for the timer slot table: directed rows and random traffic checked against a predictor.
`timescale 1ns / 1ps

module timeout_interval_timer_slots_top_tb;
    import tslot_pkg::*;

    localparam int TSLOTS        = 16;
    localparam int ISLOTS        = 16;
    localparam int DIR_ROWS      = 22;
    localparam int RANDOM_ITEMS  = 240;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 64;

    // How the expected result of a row is obtained.
    localparam int FROM_MODEL = -1;
    localparam int NO_EVENT   = 0;
    localparam int ONE_EVENT  = 1;

    typedef struct {
        t_op                op;
        logic [31:0]        now;
        logic [30:0]        duration;
        logic signed [16:0] repeat_count;
        logic [7:0]         cb_tag;
        logic [3:0]         slot;
    } timer_req_t;

    typedef struct {
        t_kind      kind;
        logic [3:0] slot_index;
        logic [7:0] tag;
        logic       last;
    } slot_event_t;

    typedef struct {
        timer_req_t  req;
        int          typed_n;
        slot_event_t typed_ev;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tslot_in_if  in_ch ();
    tslot_out_if out_ch ();

    timeout_interval_timer_slots_top #(
        .TIMEOUT_SLOTS  (TSLOTS),
        .INTERVAL_SLOTS (ISLOTS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted slot tables
    logic               to_armed    [TSLOTS];
    logic [31:0]        to_deadline [TSLOTS];
    logic [7:0]         to_tag      [TSLOTS];
    logic [30:0]        iv_period   [ISLOTS];
    logic [31:0]        iv_due      [ISLOTS];
    logic signed [16:0] iv_limit    [ISLOTS];
    logic [15:0]        iv_fired    [ISLOTS];
    logic [7:0]         iv_tag      [ISLOTS];

    slot_event_t step_events [$];
    slot_event_t awaited_events [$];
    req_row_t    dir_rows [DIR_ROWS];

    logic [31:0] clock_ms;
    bit          in_rush  = 1'b0;
    bit          out_rush = 1'b0;
    int          errors       = 0;
    int          items_sent   = 0;
    int          events_seen  = 0;
    int          fire_count   = 0;
    int          reject_count = 0;
    int          cancel_count = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the predicted tables and collect the slot events it causes.
    function automatic void apply_timer_op(timer_req_t r);
        int         i;
        int         found;
        logic [7:0] old_tag;
        step_events.delete();
        found = -1;
        case (r.op)
            OP_SERVICE: begin
                for (i = 0; i < TSLOTS; i++) begin
                    if (to_armed[i] && to_deadline[i] < r.now) begin
                        step_events.push_back('{KIND_TIMEOUT, 4'(i), to_tag[i], 1'b0});
                        to_armed[i] = 1'b0;
                    end
                end
                for (i = 0; i < ISLOTS; i++) begin
                    if (iv_period[i] != '0 && iv_due[i] < r.now) begin
                        step_events.push_back('{KIND_INTERVAL, 4'(i), iv_tag[i], 1'b0});
                        iv_due[i]   = iv_due[i] + {1'b0, iv_period[i]};
                        iv_fired[i] = iv_fired[i] + 16'd1;
                        // drop the slot once its fire limit is reached
                        if (iv_limit[i] != REPEAT_FOREVER &&
                            $signed({1'b0, iv_fired[i]}) >= iv_limit[i]) begin
                            iv_period[i] = '0;
                            iv_fired[i]  = '0;
                        end
                    end
                end
            end
            OP_SET_TIMEOUT: begin
                if (r.duration != '0) begin
                    for (i = 0; i < TSLOTS && found < 0; i++) begin
                        if (!to_armed[i]) found = i;
                    end
                end
                if (found < 0) begin
                    step_events.push_back('{KIND_REJECTED, 4'd0, r.cb_tag, 1'b0});
                end else begin
                    to_armed[found]    = 1'b1;
                    to_deadline[found] = r.now + {1'b0, r.duration};
                    to_tag[found]      = r.cb_tag;
                    step_events.push_back('{KIND_ARMED, 4'(found), r.cb_tag, 1'b0});
                end
            end
            OP_SET_INTERVAL: begin
                if (r.duration != '0) begin
                    for (i = 0; i < ISLOTS && found < 0; i++) begin
                        if (iv_period[i] == '0) found = i;
                    end
                end
                if (found < 0) begin
                    step_events.push_back('{KIND_REJECTED, 4'd0, r.cb_tag, 1'b0});
                end else begin
                    iv_period[found] = r.duration;
                    iv_due[found]    = r.now + {1'b0, r.duration};
                    iv_limit[found]  = r.repeat_count;
                    iv_fired[found]  = '0;
                    iv_tag[found]    = r.cb_tag;
                    step_events.push_back('{KIND_ARMED, 4'(found), r.cb_tag, 1'b0});
                end
            end
            default: begin
                if (int'(r.slot) >= ISLOTS) begin
                    step_events.push_back('{KIND_REJECTED, r.slot, 8'd0, 1'b0});
                end else begin
                    old_tag = (iv_period[r.slot] != '0) ? iv_tag[r.slot] : 8'd0;
                    iv_period[r.slot] = '0;
                    iv_fired[r.slot]  = '0;
                    step_events.push_back('{KIND_CANCELLED, r.slot, old_tag, 1'b0});
                end
            end
        endcase
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_wait(bit rush);
        return rush ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic signed [16:0] pick_repeat();
        case ($urandom_range(0, 9))
            0, 1, 2: return REPEAT_FOREVER;
            8:       return -17'($urandom_range(2, 65536));
            9:       return 17'($urandom);
            default: return 17'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Hold valid through the transfer, then queue what the request should produce.
    task automatic send_item(req_row_t row);
        int gap;
        if ($urandom_range(0, 24) == 0) in_rush = !in_rush;
        gap = pick_wait(in_rush);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= row.req.op;
        in_ch.now          <= row.req.now;
        in_ch.duration     <= row.req.duration;
        in_ch.repeat_count <= row.req.repeat_count;
        in_ch.callback_tag <= row.req.cb_tag;
        in_ch.slot         <= row.req.slot;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        apply_timer_op(row.req);
        if (row.typed_n == FROM_MODEL) begin
            foreach (step_events[k]) awaited_events.push_back(step_events[k]);
        end else if (row.typed_n == ONE_EVENT) begin
            awaited_events.push_back(row.typed_ev);
        end
        items_sent++;
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_events.size() != 0);
    endtask

    // Mostly well-formed traffic around a running clock, with some raw noise.
    task automatic send_random();
        req_row_t row;
        int       pick;
        row.typed_n          = FROM_MODEL;
        row.req.now          = clock_ms;
        row.req.duration     = 31'($urandom_range(1, 48));
        row.req.repeat_count = pick_repeat();
        row.req.cb_tag       = 8'($urandom);
        row.req.slot         = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            row.req.op = OP_SERVICE;
        end else if (pick < 65) begin
            row.req.op = OP_SET_TIMEOUT;
        end else if (pick < 85) begin
            row.req.op = OP_SET_INTERVAL;
        end else if (pick < 94) begin
            row.req.op = OP_CANCEL;
        end else begin
            row.req.op           = t_op'($urandom_range(0, 3));
            row.req.now          = $urandom;
            row.req.duration     = 31'($urandom);
            row.req.repeat_count = 17'($urandom);
        end
        if ($urandom_range(0, 29) == 0) row.req.duration = '0;
        send_item(row);
        clock_ms = clock_ms + 32'($urandom_range(0, 12));
    endtask

    // Overfill both tables, fire everything at once, then cancel and flush.
    task automatic fill_and_drain();
        req_row_t row;
        int       k;
        wait_drained();
        row.typed_n  = FROM_MODEL;
        row.req.now  = clock_ms;
        row.req.slot = '0;
        for (k = 0; k < 2 * (TSLOTS + 1); k++) begin
            row.req.op           = (k <= TSLOTS) ? OP_SET_TIMEOUT : OP_SET_INTERVAL;
            row.req.duration     = 31'($urandom_range(1, 3000));
            row.req.repeat_count = pick_repeat();
            row.req.cb_tag       = 8'($urandom);
            send_item(row);
        end
        row.req.op  = OP_SERVICE;
        row.req.now = clock_ms + 32'd4000;
        send_item(row);
        row.req.op = OP_CANCEL;
        for (k = 0; k < ISLOTS; k++) begin
            row.req.slot = 4'(k);
            send_item(row);
        end
        row.req.op  = OP_SERVICE;
        row.req.now = '1;
        send_item(row);
        clock_ms = clock_ms + 32'd4000;
    endtask

    // Stimulus: reset, directed rows, random traffic, drain
    initial begin
        int n;
        int w;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_SERVICE;
        in_ch.now          <= '0;
        in_ch.duration     <= '0;
        in_ch.repeat_count <= '0;
        in_ch.callback_tag <= '0;
        in_ch.slot         <= '0;
        rst_n              <= 1'b0;
        for (n = 0; n < TSLOTS; n++) begin
            to_armed[n]    = 1'b0;
            to_deadline[n] = '0;
            to_tag[n]      = '0;
        end
        for (n = 0; n < ISLOTS; n++) begin
            iv_period[n] = '0;
            iv_due[n]    = '0;
            iv_limit[n]  = '0;
            iv_fired[n]  = '0;
            iv_tag[n]    = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        clock_ms = $urandom;

        // nothing armed after reset
        dir_rows[0]  = '{'{OP_SERVICE, 32'd0, 31'd0, 17'sd0, 8'h00, 4'd0},
                         NO_EVENT, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        // zero durations are refused
        dir_rows[1]  = '{'{OP_SET_TIMEOUT, 32'd5, 31'd0, 17'sd0, 8'hFF, 4'd0},
                         ONE_EVENT, '{KIND_REJECTED, 4'd0, 8'hFF, 1'b1}};
        dir_rows[2]  = '{'{OP_SET_INTERVAL, 32'd5, 31'd0, REPEAT_FOREVER, 8'h00, 4'd0},
                         ONE_EVENT, '{KIND_REJECTED, 4'd0, 8'h00, 1'b1}};
        // cancel of a free slot reports tag zero
        dir_rows[3]  = '{'{OP_CANCEL, 32'd0, 31'd0, 17'sd0, 8'h00, 4'd15},
                         ONE_EVENT, '{KIND_CANCELLED, 4'd15, 8'h00, 1'b1}};
        dir_rows[4]  = '{'{OP_CANCEL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 17'sd0, 8'hFF, 4'd0},
                         ONE_EVENT, '{KIND_CANCELLED, 4'd0, 8'h00, 1'b1}};
        // arm at the extremes, deadline wraps
        dir_rows[5]  = '{'{OP_SET_TIMEOUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 17'sd0, 8'hAA, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd0, 8'hAA, 1'b1}};
        dir_rows[6]  = '{'{OP_SET_TIMEOUT, 32'd0, 31'd1, 17'sd0, 8'h55, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd1, 8'h55, 1'b1}};
        dir_rows[7]  = '{'{OP_SET_INTERVAL, 32'd0, 31'd1, REPEAT_FOREVER, 8'h11, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd0, 8'h11, 1'b1}};
        dir_rows[8]  = '{'{OP_SET_INTERVAL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 17'sd0, 8'h22, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd1, 8'h22, 1'b1}};
        dir_rows[9]  = '{'{OP_SET_INTERVAL, 32'd10, 31'd5, 17'sd2, 8'h33, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd2, 8'h33, 1'b1}};
        dir_rows[10] = '{'{OP_SET_INTERVAL, 32'd0, 31'd3, 17'h10000, 8'h44, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd3, 8'h44, 1'b1}};
        dir_rows[11] = '{'{OP_SET_INTERVAL, 32'd0, 31'd1, 17'h0FFFF, 8'h66, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd4, 8'h66, 1'b1}};
        dir_rows[12] = '{'{OP_SET_TIMEOUT, 32'd0, 31'd100, 17'sd0, 8'h77, 4'd0},
                         ONE_EVENT, '{KIND_ARMED, 4'd2, 8'h77, 1'b1}};
        // deadline equal to now must not fire; then fire, step periods, hit limits
        dir_rows[13] = '{'{OP_SERVICE, 32'd1, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[14] = '{'{OP_SERVICE, 32'd2, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[15] = '{'{OP_SERVICE, 32'd16, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[16] = '{'{OP_SERVICE, 32'hFFFF_FFFF, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[17] = '{'{OP_CANCEL, 32'd0, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[18] = '{'{OP_CANCEL, 32'd0, 31'd0, 17'sd0, 8'h00, 4'd2},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[19] = '{'{OP_SET_INTERVAL, 32'd0, 31'h4000_0000, -17'sd2, 8'h99, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[20] = '{'{OP_SERVICE, 32'h8000_0000, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};
        dir_rows[21] = '{'{OP_SERVICE, 32'hFFFF_FFFF, 31'd0, 17'sd0, 8'h00, 4'd0},
                         FROM_MODEL, '{KIND_TIMEOUT, 4'd0, 8'h00, 1'b1}};

        foreach (dir_rows[r]) send_item(dir_rows[r]);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 80 == 40) fill_and_drain();
            send_random();
        end

        // Drop valid and let the last results come out
        in_ch.valid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && awaited_events.size() != 0; w++) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_events.size() != 0) begin
            $display("%0t ns: %0d results never arrived, first expected kind=%0d slot=%0d tag=%0h",
                     $time, awaited_events.size(), awaited_events[0].kind,
                     awaited_events[0].slot_index, awaited_events[0].tag);
            errors += awaited_events.size();
        end

        $display("Sent %0d requests (%0d directed), checked %0d results.",
                 items_sent, DIR_ROWS, events_seen);
        $display("Fires: %0d, rejections: %0d, cancels: %0d.",
                 fire_count, reject_count, cancel_count);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: stall a random number of cycles before each transfer
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 24) == 0) out_rush = !out_rush;
            stall = pick_wait(out_rush);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge clk) begin
        slot_event_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            events_seen++;
            if (out_ch.kind == KIND_TIMEOUT || out_ch.kind == KIND_INTERVAL) fire_count++;
            if (out_ch.kind == KIND_REJECTED) reject_count++;
            if (out_ch.kind == KIND_CANCELLED) cancel_count++;
            if (awaited_events.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, %s%0d slot=%0d tag=%0h last=%0b",
                         $time, "got kind=", out_ch.kind, out_ch.slot_index, out_ch.tag,
                         out_ch.last);
                errors++;
            end else begin
                want = awaited_events.pop_front();
                check_field("kind", want.kind, out_ch.kind);
                check_field("slot_index", want.slot_index, out_ch.slot_index);
                check_field("tag", want.tag, out_ch.tag);
                check_field("last", want.last, out_ch.last);
            end
        end
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("%0t ns: timeout with %0d results outstanding", $time, awaited_events.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
